### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file of the rotary encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/rei_pkg.sv
// Types, constants and the quadrature step table of the rotary encoder core.
`timescale 1ns / 1ps
`default_nettype none
package rei_pkg;

  localparam int DELTA_WIDTH = 8;
  localparam int DEB_WIDTH   = 4;
  localparam int CUR_WIDTH   = 3;
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;

  localparam logic [7:0] CURSOR_MASK = 8'h0F;
  localparam logic [7:0] DIR_MASK    = 8'h30;
  localparam logic [7:0] DIR_CW      = 8'h10;
  localparam logic [7:0] DIR_CCW     = 8'h20;

  localparam logic [DEB_WIDTH-1:0]   DEBOUNCE_RESET = DEB_WIDTH'(3);
  localparam logic [CUR_WIDTH-1:0]   CURSOR_START   = '0;
  localparam logic [DELTA_WIDTH-1:0] DELTA_ONE      = DELTA_WIDTH'(1);
  localparam logic [DELTA_WIDTH-1:0] DELTA_MINUS    = '1;

  // Indexed by [cursor][{dt, clk}]; low nibble is the next cursor, bits 5:4 the detent.
  localparam logic [7:0] QUAD_NEXT [8][4] = '{
    '{8'h00, 8'h02, 8'h04, 8'h00},
    '{8'h03, 8'h00, 8'h01, DIR_CW},
    '{8'h03, 8'h02, 8'h00, 8'h00},
    '{8'h03, 8'h02, 8'h01, 8'h00},
    '{8'h06, 8'h00, 8'h04, 8'h00},
    '{8'h06, 8'h05, 8'h00, DIR_CCW},
    '{8'h06, 8'h05, 8'h04, 8'h00},
    '{8'h00, 8'h02, 8'h04, 8'h00}
  };

  typedef enum logic [1:0] {
    ACT_POLL         = 2'd0,
    ACT_READ_DELTA   = 2'd1,
    ACT_READ_PRESS   = 2'd2,
    ACT_READ_RELEASE = 2'd3
  } action_t;

  typedef enum logic {
    REG_INVERT   = 1'b0,
    REG_DEBOUNCE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                 invert;
    logic [DEB_WIDTH-1:0] debounce_polls;
  } cfg_t;

  typedef struct packed {
    logic cw;
    logic ccw;
  } detent_t;

  typedef struct packed {
    logic poll;
    logic clr_press;
    logic clr_release;
  } sw_ctrl_t;

  typedef struct packed {
    logic held_next;
    logic prs_flag;
    logic rel_flag;
  } sw_stat_t;

endpackage
`default_nettype wire

### rtl/core/rei_cfg.sv
// Configuration register file on the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module rei_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rei_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [rei_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [rei_pkg::PDATA_WIDTH-1:0] prdata,
  output rei_pkg::cfg_t                   cfg
);
  import rei_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert         <= 1'b0;
      cfg.debounce_polls <= DEBOUNCE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_INVERT:   cfg.invert         <= pwdata[0];
        REG_DEBOUNCE: cfg.debounce_polls <= pwdata[DEB_WIDTH-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_INVERT:   prdata[0]             = cfg.invert;
      REG_DEBOUNCE: prdata[DEB_WIDTH-1:0] = cfg.debounce_polls;
      default:      prdata                = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/rei_quad.sv
// Full-step quadrature state register and table step.
`timescale 1ns / 1ps
`default_nettype none
module rei_quad (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             clk_level,
  input  logic             dt_level,
  output rei_pkg::detent_t detent
);
  import rei_pkg::*;

  logic [CUR_WIDTH-1:0] cursor;
  logic [CUR_WIDTH-1:0] cursor_next;
  logic [7:0]           entry;
  logic [7:0]           cur_bits;
  logic [7:0]           dir_bits;

  assign entry       = QUAD_NEXT[cursor][{dt_level, clk_level}];
  assign cur_bits    = entry & CURSOR_MASK;
  assign cursor_next = cur_bits[CUR_WIDTH-1:0];
  assign dir_bits    = entry & DIR_MASK;
  assign detent.cw   = (dir_bits == DIR_CW);
  assign detent.ccw  = (dir_bits == DIR_CCW);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= CURSOR_START;
    end else if (step) begin
      cursor <= cursor_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rei_switch.sv
// Push switch debouncer with press and release edge flags.
`timescale 1ns / 1ps
`default_nettype none
module rei_switch (
  input  logic                          clk,
  input  logic                          rst,
  input  rei_pkg::sw_ctrl_t             ctrl,
  input  logic                          switch_level,
  input  logic [rei_pkg::DEB_WIDTH-1:0] debounce_polls,
  output rei_pkg::sw_stat_t             stat
);
  import rei_pkg::*;

  logic                 stable;
  logic                 stable_next;
  logic [DEB_WIDTH-1:0] count;
  logic [DEB_WIDTH-1:0] count_next;
  logic [DEB_WIDTH:0]   count_inc;
  logic                 prs;
  logic                 prs_next;
  logic                 rel;
  logic                 rel_next;
  logic                 pressed;

  assign pressed   = ~switch_level;
  assign count_inc = {1'b0, count} + (DEB_WIDTH + 1)'(1);

  always_comb begin
    stable_next = stable;
    count_next  = count;
    prs_next    = prs & ~ctrl.clr_press;
    rel_next    = rel & ~ctrl.clr_release;
    if (ctrl.poll) begin
      if (pressed != stable) begin
        // accept the change once enough differing samples in a row are seen
        if (count_inc >= {1'b0, debounce_polls}) begin
          stable_next = pressed;
          count_next  = '0;
          if (pressed) begin
            prs_next = 1'b1;
          end else begin
            rel_next = 1'b1;
          end
        end else begin
          count_next = count_inc[DEB_WIDTH-1:0];
        end
      end else begin
        count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      count  <= '0;
      prs    <= 1'b0;
      rel    <= 1'b0;
    end else begin
      stable <= stable_next;
      count  <= count_next;
      prs    <= prs_next;
      rel    <= rel_next;
    end
  end

  assign stat.held_next = stable_next;
  assign stat.prs_flag  = prs;
  assign stat.rel_flag  = rel;

endmodule
`default_nettype wire

### rtl/core/rotary_encoder_interface_core.sv
// Rotary encoder interface: quadrature decoder, detent counter and switch debouncer.
//
// Input channel (in_valid / in_stall) carries one word per action: a poll with
// sampled clk, dt and switch levels, or a read-and-clear of the delta, the press
// flag or the release flag. Every input word yields exactly one output word on
// out_valid / out_stall: delta, edge_seen and the debounced switch_held level.
// A word is taken on a rising edge with valid high and stall low.
// The accepting edge loads the input register; the word then moves through the
// table step and counter update into the output register and raises out_valid.
// One word per cycle is sustained; the only limit is the output register, which
// holds its word while out_stall is high and stalls the input only once the input
// register is full as well.
// Reset (rst, synchronous) empties both registers, puts the decoder in its start
// state, clears the delta and both edge flags, marks the switch released, and
// loads invert = 0 and debounce_polls = 3. Registers on the APB port are at byte
// offsets 0 (invert) and 4 (debounce_polls); pready is always high.
`timescale 1ns / 1ps
`default_nettype none
module rotary_encoder_interface_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             action,
  input  logic                                   clk_level,
  input  logic                                   dt_level,
  input  logic                                   switch_level,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rei_pkg::DELTA_WIDTH-1:0] delta,
  output logic                                   edge_seen,
  output logic                                   switch_held,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rei_pkg::PADDR_WIDTH-1:0]        paddr,
  input  logic [rei_pkg::PDATA_WIDTH-1:0]        pwdata,
  output logic [rei_pkg::PDATA_WIDTH-1:0]        prdata,
  output logic                                   pready
);
  import rei_pkg::*;

  cfg_t     cfg;
  detent_t  detent;
  sw_ctrl_t sw_ctrl;
  sw_stat_t sw_stat;

  // input register
  logic    in_full;
  action_t in_act;
  logic    in_clk;
  logic    in_dt;
  logic    in_sw;

  logic                   accept;
  logic                   advance;
  logic                   out_valid_next;
  logic [DELTA_WIDTH-1:0] detent_total;
  logic [DELTA_WIDTH-1:0] detent_total_next;
  logic [DELTA_WIDTH-1:0] poll_total;
  logic [DELTA_WIDTH-1:0] delta_next;
  logic                   edge_next;

  assign pready   = 1'b1;
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign out_valid_next = advance || (out_valid && out_stall);

  rei_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rei_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .step      (sw_ctrl.poll),
    .clk_level (in_clk),
    .dt_level  (in_dt),
    .detent    (detent)
  );

  assign sw_ctrl.poll        = advance && (in_act == ACT_POLL);
  assign sw_ctrl.clr_press   = advance && (in_act == ACT_READ_PRESS);
  assign sw_ctrl.clr_release = advance && (in_act == ACT_READ_RELEASE);

  rei_switch u_switch (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (sw_ctrl),
    .switch_level   (in_sw),
    .debounce_polls (cfg.debounce_polls),
    .stat           (sw_stat)
  );

  // step the accumulator by one detent, sign swapped when inverted
  always_comb begin
    poll_total = detent_total;
    if (detent.cw) begin
      poll_total = detent_total + (cfg.invert ? DELTA_MINUS : DELTA_ONE);
    end else if (detent.ccw) begin
      poll_total = detent_total + (cfg.invert ? DELTA_ONE : DELTA_MINUS);
    end
  end

  always_comb begin
    detent_total_next = detent_total;
    delta_next        = detent_total;
    edge_next         = 1'b0;
    case (in_act)
      ACT_POLL: begin
        detent_total_next = poll_total;
        delta_next        = poll_total;
      end
      ACT_READ_DELTA:   detent_total_next = '0;
      ACT_READ_PRESS:   edge_next = sw_stat.prs_flag;
      ACT_READ_RELEASE: edge_next = sw_stat.rel_flag;
      default:          edge_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      out_valid    <= 1'b0;
      detent_total <= '0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      out_valid <= out_valid_next;
      if (advance) begin
        detent_total <= detent_total_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_act <= action_t'(action);
      in_clk <= clk_level;
      in_dt  <= dt_level;
      in_sw  <= switch_level;
    end
    if (advance) begin
      delta       <= delta_next;
      edge_seen   <= edge_next;
      switch_held <= sw_stat.held_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rei_checker.sv
// Port-level checks of the rotary encoder core and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rei_checker (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   in_valid,
  input wire logic                                   in_stall,
  input wire logic                                   out_valid,
  input wire logic                                   out_stall,
  input wire logic signed [rei_pkg::DELTA_WIDTH-1:0] delta,
  input wire logic                                   edge_seen,
  input wire logic                                   switch_held
);

  // the input side only backs up when the output word is held
  `ASSERT_CLK(a_stall_cause, in_stall |-> (out_valid && out_stall), "in_stall without output stall")

  // an accepted word is moved to the output when the output drains
  `ASSERT_CLK(a_latency, (in_valid && !in_stall) ##1 !out_stall |=> out_valid, "result word late")

  // a held output word keeps its payload
  `ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(delta) && $stable(edge_seen) && $stable(switch_held)), "stalled output word changed")

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "out_valid after reset")

endmodule

bind rotary_encoder_interface_core rei_checker u_rei_checker (.*);
`default_nettype wire

### sim/rotary_encoder_checker.sv
// Output predictor and comparator for the rotary encoder interface core.
`timescale 1ns / 1ps
module rotary_encoder_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [1:0]                             action,
  input  logic                                   clk_level,
  input  logic                                   dt_level,
  input  logic                                   switch_level,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [rei_pkg::DELTA_WIDTH-1:0] delta,
  input  logic                                   edge_seen,
  input  logic                                   switch_held,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic                                   pready,
  input  logic [rei_pkg::PADDR_WIDTH-1:0]        paddr,
  input  logic [rei_pkg::PDATA_WIDTH-1:0]        pwdata,
  output int                                     fail_count,
  output int                                     pending
);
  import rei_pkg::*;

  typedef struct packed {
    logic signed [DELTA_WIDTH-1:0] delta;
    logic                          edge_seen;
    logic                          switch_held;
  } encoder_word_t;

  // Step code: {cw, ccw, next cursor}.
  localparam logic [4:0] TURN_CW  = 5'b10_000;
  localparam logic [4:0] TURN_CCW = 5'b01_000;

  logic [2:0]             cursor;
  logic [DELTA_WIDTH-1:0] detents;
  logic                   debounced;
  logic                   press_latched;
  logic                   release_latched;
  logic [4:0]             differ_run;
  logic                   invert_cfg;
  logic [DEB_WIDTH-1:0]   debounce_cfg;
  encoder_word_t          results_due[$];

  // Rows hold the four entries {pins 3, pins 2, pins 1, pins 0}, pins = {dt, clk}.
  function automatic logic [4:0] quad_step(input logic [2:0] cur, input logic [1:0] pins);
    logic [19:0] row;
    case (cur)
      3'd1:    row = {TURN_CW,  5'd1, 5'd0, 5'd3};
      3'd2:    row = {5'd0,     5'd0, 5'd2, 5'd3};
      3'd3:    row = {5'd0,     5'd1, 5'd2, 5'd3};
      3'd4:    row = {5'd0,     5'd4, 5'd0, 5'd6};
      3'd5:    row = {TURN_CCW, 5'd0, 5'd5, 5'd6};
      3'd6:    row = {5'd0,     5'd4, 5'd5, 5'd6};
      default: row = {5'd0,     5'd4, 5'd2, 5'd0};  // start state; unused code 7 maps here
    endcase
    return row[pins*5 +: 5];
  endfunction

  function automatic encoder_word_t predict_word(input action_t act, input logic a,
                                                 input logic b, input logic sw);
    encoder_word_t w;
    logic [4:0]    step;
    logic          pressed;
    w.edge_seen = 1'b0;
    case (act)
      ACT_POLL: begin
        step = quad_step(cursor, {b, a});
        cursor = step[2:0];
        if ((step & TURN_CW) != '0)
          detents = invert_cfg ? detents - 1'b1 : detents + 1'b1;
        else if ((step & TURN_CCW) != '0)
          detents = invert_cfg ? detents + 1'b1 : detents - 1'b1;
        pressed = ~sw;
        if (pressed != debounced) begin
          differ_run = differ_run + 1'b1;
          // a threshold of zero accepts the first differing sample
          if (differ_run >= debounce_cfg) begin
            debounced = pressed;
            differ_run = '0;
            if (pressed) press_latched = 1'b1;
            else release_latched = 1'b1;
          end
        end else begin
          differ_run = '0;
        end
        w.delta = detents;
      end
      ACT_READ_DELTA: begin
        w.delta = detents;
        detents = '0;
      end
      ACT_READ_PRESS: begin
        w.delta = detents;
        w.edge_seen = press_latched;
        press_latched = 1'b0;
      end
      default: begin
        w.delta = detents;
        w.edge_seen = release_latched;
        release_latched = 1'b0;
      end
    endcase
    w.switch_held = debounced;
    return w;
  endfunction

  always @(posedge clk) begin
    encoder_word_t want;
    if (rst) begin
      cursor = '0;
      detents = '0;
      debounced = 1'b0;
      press_latched = 1'b0;
      release_latched = 1'b0;
      differ_run = '0;
      invert_cfg = 1'b0;
      debounce_cfg = 4'd3;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_INVERT: invert_cfg = pwdata[0];
          default:    debounce_cfg = pwdata[DEB_WIDTH-1:0];
        endcase
      end
      if (in_valid && !in_stall)
        results_due.push_back(predict_word(action_t'(action), clk_level, dt_level,
                                           switch_level));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("output word with none expected: delta %0d edge_seen %0b switch_held %0b",
                 delta, edge_seen, switch_held);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (delta !== want.delta) begin
            $error("delta: expected %0d, got %0d", want.delta, delta);
            fail_count++;
          end
          if (edge_seen !== want.edge_seen) begin
            $error("edge_seen: expected %0b, got %0b", want.edge_seen, edge_seen);
            fail_count++;
          end
          if (switch_held !== want.switch_held) begin
            $error("switch_held: expected %0b, got %0b", want.switch_held, switch_held);
            fail_count++;
          end
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

### sim/tb_rotary_encoder_interface_core.sv
// Stimulus and verdict for the rotary encoder interface core.
`timescale 1ns / 1ps
module tb_rotary_encoder_interface_core;
  import rei_pkg::*;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    action = ACT_POLL;
  logic                          clk_level = 1'b1;
  logic                          dt_level = 1'b1;
  logic                          switch_level = 1'b1;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [DELTA_WIDTH-1:0] delta;
  logic                          edge_seen;
  logic                          switch_held;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0]        paddr = '0;
  logic [PDATA_WIDTH-1:0]        pwdata = '0;
  logic [PDATA_WIDTH-1:0]        prdata;
  logic                          pready;

  int   fail_count;
  int   pending;
  int   words_sent = 0;
  bit   steady = 1'b0;
  int   hold_request = 0;
  int   hold_left = 0;
  logic switch_pin = 1'b1;

  // Pin patterns of one detent, step i in bit i: clockwise leads on clk.
  localparam logic [3:0] LEAD_SEQ  = 4'b1001;
  localparam logic [3:0] TRAIL_SEQ = 4'b1100;

  rotary_encoder_interface_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .clk_level(clk_level), .dt_level(dt_level),
    .switch_level(switch_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .delta(delta), .edge_seen(edge_seen), .switch_held(switch_held),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rotary_encoder_checker watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .clk_level(clk_level), .dt_level(dt_level),
    .switch_level(switch_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .delta(delta), .edge_seen(edge_seen), .switch_held(switch_held),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 11);
    end
  end

  task automatic send_word(input logic [1:0] act, input logic a, input logic b,
                           input logic sw);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    clk_level <= a;
    dt_level <= b;
    switch_level <= sw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Switch pin with long runs and the odd single-poll glitch.
  function automatic logic next_switch();
    if ($urandom_range(19) == 0) switch_pin = ~switch_pin;
    return ($urandom_range(29) == 0) ? ~switch_pin : switch_pin;
  endfunction

  task automatic turn(input bit ccw, input int steps, input bit noisy);
    logic a;
    logic b;
    for (int i = 0; i < steps; i++) begin
      a = ccw ? TRAIL_SEQ[i] : LEAD_SEQ[i];
      b = ccw ? LEAD_SEQ[i] : TRAIL_SEQ[i];
      send_word(ACT_POLL, a, b, noisy ? next_switch() : switch_pin);
    end
  endtask

  task automatic random_burst(input int count);
    int stop;
    int pick;
    stop = words_sent + count;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        turn(1'($urandom_range(1)), 4, 1'b1);
      end else if (pick < 65) begin
        // abandon a detent part way and bounce
        turn(1'($urandom_range(1)), $urandom_range(1, 3), 1'b1);
        send_word(ACT_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)), next_switch());
      end else if (pick < 75) begin
        send_word(ACT_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)), next_switch());
      end else begin
        send_word(2'($urandom_range(ACT_READ_DELTA, ACT_READ_RELEASE)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Drop valid and wait until every expected word is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_WIDTH'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic inv, input logic [DEB_WIDTH-1:0] polls);
    write_reg(REG_INVERT, PDATA_WIDTH'(inv));
    write_reg(REG_DEBOUNCE, PDATA_WIDTH'(polls));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: no inversion, three polls of debounce.
    send_word(ACT_POLL, 1'b1, 1'b1, 1'b1);
    turn(1'b0, 4, 1'b0);
    turn(1'b1, 4, 1'b0);
    turn(1'b1, 4, 1'b0);
    // bounce from a half step back to start
    send_word(ACT_POLL, 1'b1, 1'b0, 1'b1);
    send_word(ACT_POLL, 1'b0, 1'b1, 1'b1);
    send_word(ACT_READ_DELTA, 1'b0, 1'b0, 1'b0);
    repeat (3) send_word(ACT_POLL, 1'b1, 1'b1, 1'b0);
    send_word(ACT_READ_PRESS, 1'b0, 1'b1, 1'b0);
    send_word(ACT_READ_PRESS, 1'b1, 1'b0, 1'b1);
    repeat (3) send_word(ACT_POLL, 1'b1, 1'b1, 1'b1);
    send_word(ACT_READ_RELEASE, 1'b0, 1'b0, 1'b1);
    send_word(ACT_READ_RELEASE, 1'b1, 1'b1, 1'b0);
    drain();

    set_config(1'b1, 4'd15);
    steady = 1'b1;
    random_burst(60);
    drain();
    steady = 1'b0;

    set_config(1'b0, 4'd1);
    hold_request = 60;
    random_burst(60);
    drain();

    set_config(1'b1, 4'd0);
    random_burst(30);
    drain();
    random_burst(30);
    drain();

    set_config(1'b0, 4'd7);
    hold_request = 80;
    random_burst(70);
    drain();

    // Run the detent counter well up, then partly back down.
    set_config(1'b0, 4'd15);
    send_word(ACT_READ_DELTA, 1'b1, 1'b1, 1'b1);
    repeat (20) turn(1'b0, 4, 1'b1);
    repeat (5) turn(1'b1, 4, 1'b1);
    send_word(ACT_READ_DELTA, 1'b0, 1'b1, 1'b0);
    drain();

    set_config(1'b1, 4'd3);
    random_burst(70);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rei_pkg.sv
rtl/core/rei_cfg.sv
rtl/core/rei_quad.sv
rtl/core/rei_switch.sv
rtl/core/rotary_encoder_interface_core.sv
rtl/core/rei_checker.sv
sim/rotary_encoder_checker.sv
sim/tb_rotary_encoder_interface_core.sv
